@@ rtl/core/lgb_pkg.sv @@
package lgb_pkg;

    // Field and datapath widths
    localparam int LIMB_W  = 64;
    localparam int DIGIT_W = 19;
    localparam int IDX_W   = 20;
    localparam int KW      = 5;
    localparam int AVAIL_W = 7;
    // Window: one limb above at most DIGIT_W-1 leftover bits
    localparam int BUF_W   = LIMB_W + DIGIT_W - 1;

    localparam logic [KW-1:0]      K_MIN     = 5'd8;
    localparam logic [KW-1:0]      K_MAX     = 5'd19;
    localparam logic [KW-1:0]      K_RESET   = 5'd16;
    localparam logic [AVAIL_W-1:0] LIMB_BITS = 7'd64;

    typedef enum logic {
        ST_IDLE,
        ST_SLICE
    } seq_state_t;

    // Sequencer commands to the shift unit
    typedef struct packed {
        logic          load;
        logic          shift;
        logic [KW-1:0] keep_bits;
        logic [KW-1:0] width;
    } shf_ctrl_t;

    // One digit handed to the output stage
    typedef struct packed {
        logic               valid;
        logic [DIGIT_W-1:0] digit;
        logic [DIGIT_W-1:0] index;
        logic               last;
    } emit_t;

    // Low w bits set
    function automatic logic [DIGIT_W-1:0] digit_mask(input logic [KW-1:0] w);
        logic [31:0] m;
        m = (32'd1 << w) - 32'd1;
        return m[DIGIT_W-1:0];
    endfunction

    // Legal digit width from a register write
    function automatic logic [KW-1:0] clamp_width(input logic [KW-1:0] v);
        logic [KW-1:0] r;
        r = v;
        if (v < K_MIN)
            r = K_MIN;
        else if (v > K_MAX)
            r = K_MAX;
        return r;
    endfunction

endpackage

@@ rtl/core/lgb_shifter.sv @@
module lgb_shifter
    import lgb_pkg::*;
(
    input  logic               clk,
    input  shf_ctrl_t          ctrl,
    input  logic [LIMB_W-1:0]  limb,
    output logic [DIGIT_W-1:0] low_bits
);

    logic [BUF_W-1:0] buf_reg;
    logic [BUF_W-1:0] buf_next;

    // Load puts the limb above the kept leftover bits; shift drops one digit
    always_comb
    begin
        buf_next = buf_reg;
        if (ctrl.load)
        begin
            buf_next = (BUF_W'(limb) << ctrl.keep_bits)
                     | BUF_W'(buf_reg[DIGIT_W-1:0] & digit_mask(ctrl.keep_bits));
        end
        else if (ctrl.shift)
        begin
            buf_next = buf_reg >> ctrl.width;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    assign low_bits = buf_reg[DIGIT_W-1:0];

endmodule

@@ rtl/core/lgb_seq.sv @@
module lgb_seq
    import lgb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               last_limb,
    output logic               in_ready,
    input  logic               cfg_we,
    input  logic [KW-1:0]      cfg_wdata,
    input  logic [DIGIT_W-1:0] low_bits,
    input  logic               out_free,
    output shf_ctrl_t          ctrl,
    output emit_t              emit
);

    seq_state_t          state_reg, state_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [KW-1:0]       pend_cnt_reg, pend_cnt_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [AVAIL_W-1:0]  avail_reg, avail_next;
    logic                last_reg, last_next;

    logic [KW-1:0]       keep;
    logic                take_full;
    logic [AVAIL_W-1:0]  avail_after;
    logic                done;

    // Leftover bits in the window and what one slice leaves
    assign keep        = (pend_cnt_reg >= k_reg) ? '0 : pend_cnt_reg;
    assign take_full   = avail_reg >= {2'b00, k_reg};
    assign avail_after = avail_reg - {2'b00, k_reg};
    assign done        = take_full
                       ? (last_reg ? (avail_after == '0) : (avail_after < {2'b00, k_reg}))
                       : 1'b1;
    assign in_ready    = (state_reg == ST_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_SLICE;
            end
            ST_SLICE:
            begin
                if (out_free && done)
                    state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath commands, digits and counters
    always_comb
    begin
        k_next        = k_reg;
        pend_cnt_next = pend_cnt_reg;
        idx_next      = idx_reg;
        avail_next    = avail_reg;
        last_next     = last_reg;
        ctrl          = '0;
        ctrl.keep_bits = keep;
        ctrl.width     = k_reg;
        emit          = '0;
        emit.index    = idx_reg[DIGIT_W-1:0];
        emit.digit    = low_bits & digit_mask(k_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    avail_next = LIMB_BITS + {2'b00, keep};
                    last_next  = last_limb;
                end
            end
            ST_SLICE:
            begin
                if (out_free)
                begin
                    emit.valid = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    if (take_full)
                    begin
                        ctrl.shift = 1'b1;
                        avail_next = avail_after;
                        emit.last  = last_reg && (avail_after == '0);
                    end
                    else
                    begin
                        // final partial digit, zero-extended
                        emit.digit = low_bits & digit_mask(avail_reg[KW-1:0]);
                        emit.last  = 1'b1;
                    end
                    if (done)
                    begin
                        if (last_reg)
                        begin
                            pend_cnt_next = '0;
                            idx_next      = '0;
                        end
                        else
                        begin
                            pend_cnt_next = avail_after[KW-1:0];
                        end
                    end
                end
            end
        endcase

        // Width write restarts the stream
        if (cfg_we)
        begin
            k_next        = clamp_width(cfg_wdata);
            pend_cnt_next = '0;
            idx_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            k_reg        <= K_RESET;
            pend_cnt_reg <= '0;
            idx_reg      <= '0;
            avail_reg    <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            pend_cnt_reg <= pend_cnt_next;
            idx_reg      <= idx_next;
            avail_reg    <= avail_next;
            last_reg     <= last_next;
        end
    end

endmodule

@@ rtl/core/limb_to_digit_gearbox_top.sv @@
// Limb to digit gearbox.
// Input channel (in_valid/in_ready): one 64-bit limb per beat, least
// significant limb first, last_limb set on the final limb of a number.
// Output channel (out_valid/out_ready): one k-bit digit per beat with its
// index in the number and last_digit on the final digit.
// cfg_we/cfg_wdata set the digit width k (clamped to 8..19) and restart the
// stream; write it only while the block is idle.
// Timing: a limb is loaded into the window, then one shift unit slices one
// digit per cycle from the window while the output register is free; the
// last limb may end in a zero-extended partial digit. The first digit is
// sliced once the limb is in the window and then held in the output register.
// in_ready is high only between limbs.
// Reset: k = 16, no leftover bits, digit index 0, output empty.
// When the receiver stalls the digit holds in the output register and the
// slicer waits; no digits are dropped.
module limb_to_digit_gearbox_top
    import lgb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [LIMB_W-1:0]  limb,
    input  logic               last_limb,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [DIGIT_W-1:0] digit,
    output logic [DIGIT_W-1:0] digit_index,
    output logic               last_digit,
    input  logic               cfg_we,
    input  logic [KW-1:0]      cfg_wdata
);

    shf_ctrl_t          ctrl;
    emit_t              emit;
    logic [DIGIT_W-1:0] low_bits;
    logic               out_free;

    logic               out_valid_reg;
    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] index_reg;
    logic               last_reg;

    assign out_free = !out_valid_reg || out_ready;

    lgb_shifter u_shifter (
        .clk      (clk),
        .ctrl     (ctrl),
        .limb     (limb),
        .low_bits (low_bits)
    );

    lgb_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_limb (last_limb),
        .in_ready  (in_ready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .low_bits  (low_bits),
        .out_free  (out_free),
        .ctrl      (ctrl),
        .emit      (emit)
    );

    // Output register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit.valid)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Output register: payload
    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            digit_reg <= emit.digit;
            index_reg <= emit.index;
            last_reg  <= emit.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign digit       = digit_reg;
    assign digit_index = index_reg;
    assign last_digit  = last_reg;

`ifndef SYNTHESIS
    // In the cycle after a limb is taken the slicer is busy and in_ready is low
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready high right after a limb was taken");

    // Back-to-back digits of a number carry consecutive indices
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_digit ##1 out_valid
        |-> digit_index == DIGIT_W'($past(digit_index) + 1'b1))
        else $error("digit index did not advance by one");

    // The digit after a final digit starts a new number
    a_index_restart: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_digit ##1 out_valid
        |-> digit_index == '0)
        else $error("digit index did not restart after final digit");
`endif

endmodule
